>>> rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the congestion window controller
// Event codes, phase encoding, controller state and result records, and the
// small arithmetic helpers used by the update logic.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int unsigned WORD_W     = 32;
	localparam int unsigned INIT_WIN_W = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned IN_DATA_W  = 3 * WORD_W;
	localparam int unsigned OUT_DATA_W = 72;

	localparam logic [INIT_WIN_W-1:0] DEF_INIT_WINDOW    = 16'd4;
	localparam logic [WORD_W-1:0]     DEF_INIT_THRESHOLD = 32'd4096;
	localparam logic [WORD_W-1:0]     ALL_ONES           = '1;
	localparam logic [WORD_W-1:0]     MIN_THRESHOLD      = 32'd2;
	localparam logic [WORD_W-1:0]     RETX_BUMP          = 32'd3;
	localparam logic [WORD_W-1:0]     TIMEOUT_WINDOW     = 32'd1;
	localparam logic [1:0]            DUP_LIMIT          = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_WINDOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_THRESHOLD = 2'd1;

	// event kinds carried in the input tuser
	typedef enum logic [1:0] {
		MODE_ACK     = 2'd0,
		MODE_TIMEOUT = 2'd1,
		MODE_CONFIRM = 2'd2,
		MODE_QUERY   = 2'd3
	} mode_t;

	// controller phase, one-hot internally
	typedef enum logic [3:0] {
		PH_SLOW  = 4'b0001,
		PH_AVOID = 4'b0010,
		PH_RETX  = 4'b0100,
		PH_RECOV = 4'b1000
	} phase_t;

	// external phase codes
	localparam logic [1:0] PCODE_SLOW  = 2'd0;
	localparam logic [1:0] PCODE_AVOID = 2'd1;
	localparam logic [1:0] PCODE_RETX  = 2'd2;
	localparam logic [1:0] PCODE_RECOV = 2'd3;

	typedef struct packed {
		logic [WORD_W-1:0] window;
		logic [WORD_W-1:0] threshold;
		phase_t            phase;
		logic [1:0]        dup_count;
		logic [WORD_W-1:0] prev_ack;
		logic [WORD_W-1:0] timeout_ack;
		logic [WORD_W-1:0] acked_in_round;
	} cc_state_t;

	typedef struct packed {
		logic [WORD_W-1:0] window_size;
		logic [WORD_W-1:0] threshold;
		logic [1:0]        phase;
		logic              confirmed;
		logic              send_allowed;
	} cc_result_t;

	// restart request from the configuration side
	typedef struct packed {
		logic                  load;
		logic [INIT_WIN_W-1:0] window;
		logic [WORD_W-1:0]     threshold;
	} cfg_load_t;

	function automatic logic [1:0] phase_code(input phase_t ph);
		logic [1:0] code;
		case (ph)
			PH_SLOW:  code = PCODE_SLOW;
			PH_AVOID: code = PCODE_AVOID;
			PH_RETX:  code = PCODE_RETX;
			PH_RECOV: code = PCODE_RECOV;
			default:  code = PCODE_SLOW;
		endcase
		return code;
	endfunction

	function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] v);
		return (v == ALL_ONES) ? v : v + 32'd1;
	endfunction

	function automatic logic [WORD_W-1:0] halve(input logic [WORD_W-1:0] win);
		return (win > MIN_THRESHOLD) ? (win >> 1) : MIN_THRESHOLD;
	endfunction

	// state right after reset or a configuration write
	function automatic cc_state_t fresh_state(input logic [INIT_WIN_W-1:0] win,
			input logic [WORD_W-1:0] thr);
		cc_state_t s;
		s.window         = {{(WORD_W-INIT_WIN_W){1'b0}}, win};
		s.threshold      = thr;
		s.phase          = PH_SLOW;
		s.dup_count      = 2'd0;
		s.prev_ack       = ALL_ONES;
		s.timeout_ack    = ALL_ONES;
		s.acked_in_round = '0;
		return s;
	endfunction

endpackage

>>> rtl/tcp_congestion_window_fsm.sv
// ----------------------------------------------------------------------------
// tcp_congestion_window_fsm: Reno-style congestion window controller
// Input register, combinational state update and a result register.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the s_axis channel is one event: an ack arrival, a timeout,
// a retransmit confirmation or a send query, selected by s_axis_tuser. Every
// request yields exactly one result on m_axis with the window, threshold and
// phase after the event, plus the confirm and send-allowed flags.
// An accepted request is loaded into the input register, and m_axis_tvalid
// rises when the result register is loaded from it.
// Throughput is one request per cycle while m_axis_tready is high; the state
// lives in a single register updated by the update logic, which sets that rate.
// While the receiver stalls, the finished result waits in the result register
// and one more request is held in the input register; s_axis_tready then
// drops until m_axis_tready returns.
// Reset loads window 4 and threshold 4096 in slow start. A write to a known cfg
// register stores it and restarts the controller with the new values in the
// same cycle; writes are always accepted. The user must make writes only while
// no request is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module tcp_congestion_window_fsm (
	input  logic                              clk,
	input  logic                              arst_n,
	// tdata: ack_number, window_base, next_sequence
	input  logic [tcw_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// tuser: mode
	input  logic [1:0]                        s_axis_tuser,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// tdata: window_size, threshold, phase, confirmed, send_allowed, zero pad
	output logic [tcw_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tcw_pkg::WORD_W-1:0]        cfg_data
);
	import tcw_pkg::*;

	localparam int unsigned PAD_W = OUT_DATA_W - (3 * WORD_W - WORD_W + 4);

	cfg_load_t         restart;
	cc_state_t         state_q;
	cc_state_t         state_nxt;
	cc_result_t        res;
	logic              valid_s1;
	mode_t             mode_s1;
	logic [WORD_W-1:0] ack_s1;
	logic [WORD_W-1:0] base_s1;
	logic [WORD_W-1:0] next_s1;
	logic              out_valid_q;
	cc_result_t        out_q;
	logic              advance;

	tcw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.restart   (restart)
	);

	tcw_step u_step (
		.cur           (state_q),
		.mode          (mode_s1),
		.ack_number    (ack_s1),
		.window_base   (base_s1),
		.next_sequence (next_s1),
		.nxt           (state_nxt),
		.res           (res)
	);

	// the input stage moves on when the result register is free or draining
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			mode_s1 <= mode_t'(s_axis_tuser);
			ack_s1  <= s_axis_tdata[WORD_W-1:0];
			base_s1 <= s_axis_tdata[2*WORD_W-1:WORD_W];
			next_s1 <= s_axis_tdata[3*WORD_W-1:2*WORD_W];
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= fresh_state(DEF_INIT_WINDOW, DEF_INIT_THRESHOLD);
		else if (restart.load)
			state_q <= fresh_state(restart.window, restart.threshold);
		else if (advance)
			state_q <= state_nxt;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, out_q.send_allowed, out_q.confirmed,
		out_q.phase, out_q.threshold, out_q.window_size};

`ifndef SYNTHESIS
	// recovery phases are only reached with the duplicate count saturated
	a_recov_dup: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_RETX || state_q.phase == PH_RECOV)
		|-> state_q.dup_count == DUP_LIMIT)
		else $error("recovery phase without three duplicates");

	// a held input request is not lost while the result register is stalled
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_axis_tready |=> valid_s1)
		else $error("input stage dropped a request under stall");

	// a confirmed retransmit always reports the recovery phase
	a_confirm_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.confirmed |-> out_q.phase == PCODE_RECOV)
		else $error("confirm flag without recovery phase");

	// the two flags belong to different events
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.confirmed && out_q.send_allowed))
		else $error("confirm and send flags both set");

	// state moves only with a processed request or a restart
	a_state_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(advance) && !$past(restart.load) |-> $stable(state_q))
		else $error("controller state changed without a request");
`endif

endmodule

>>> rtl/tcw_cfg.sv
// ----------------------------------------------------------------------------
// tcw_cfg: configuration registers
// Holds the initial window and threshold and raises a restart request with
// the new values on every accepted write to a known register.
// ----------------------------------------------------------------------------
module tcw_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tcw_pkg::WORD_W-1:0]    cfg_data,
	output tcw_pkg::cfg_load_t            restart
);
	import tcw_pkg::*;

	logic [INIT_WIN_W-1:0] init_window_q;
	logic [WORD_W-1:0]     init_threshold_q;
	logic                  wr_win;
	logic                  wr_thr;

	// writes are always taken
	assign cfg_ready = 1'b1;
	assign wr_win    = cfg_valid && (cfg_index == CFG_INIT_WINDOW);
	assign wr_thr    = cfg_valid && (cfg_index == CFG_INIT_THRESHOLD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_window_q    <= DEF_INIT_WINDOW;
			init_threshold_q <= DEF_INIT_THRESHOLD;
		end else begin
			if (wr_win)
				init_window_q <= cfg_data[INIT_WIN_W-1:0];
			if (wr_thr)
				init_threshold_q <= cfg_data;
		end
	end

	// restart values include the register being written this cycle
	always_comb begin
		restart.load      = wr_win || wr_thr;
		restart.window    = wr_win ? cfg_data[INIT_WIN_W-1:0] : init_window_q;
		restart.threshold = wr_thr ? cfg_data : init_threshold_q;
	end

endmodule

>>> rtl/tcw_step.sv
// ----------------------------------------------------------------------------
// tcw_step: per-event update logic
// Combinational next state and result for one event against the current
// controller state.
// ----------------------------------------------------------------------------
module tcw_step (
	input  tcw_pkg::cc_state_t         cur,
	input  tcw_pkg::mode_t             mode,
	input  logic [tcw_pkg::WORD_W-1:0] ack_number,
	input  logic [tcw_pkg::WORD_W-1:0] window_base,
	input  logic [tcw_pkg::WORD_W-1:0] next_sequence,
	output tcw_pkg::cc_state_t         nxt,
	output tcw_pkg::cc_result_t        res
);
	import tcw_pkg::*;

	logic [WORD_W-1:0] win_inc;
	logic [WORD_W-1:0] half_thr;
	logic [WORD_W-1:0] ack_delta;
	logic [WORD_W:0]   round_sum;
	logic [WORD_W-1:0] round_sat;
	logic [1:0]        dup_inc;
	logic              confirmed;
	logic              allowed;

	assign win_inc   = sat_inc(cur.window);
	assign half_thr  = halve(cur.window);
	assign ack_delta = ack_number - cur.prev_ack;
	assign round_sum = {1'b0, cur.acked_in_round} + {1'b0, ack_delta};
	assign round_sat = round_sum[WORD_W] ? ALL_ONES : round_sum[WORD_W-1:0];
	assign dup_inc   = (cur.dup_count == DUP_LIMIT) ? DUP_LIMIT : cur.dup_count + 2'd1;

	always_comb begin
		nxt       = cur;
		confirmed = 1'b0;
		allowed   = 1'b0;
		case (mode)
			MODE_ACK: begin
				if (ack_number == cur.prev_ack) begin
					// duplicate ack
					if (cur.phase == PH_RETX || cur.phase == PH_RECOV) begin
						nxt.window = win_inc;
					end else begin
						nxt.dup_count = dup_inc;
						if (dup_inc == DUP_LIMIT) begin
							nxt.threshold = half_thr;
							nxt.window    = half_thr + RETX_BUMP;
							nxt.phase     = PH_RETX;
						end
					end
				end else begin
					// new ack
					nxt.dup_count = 2'd0;
					nxt.prev_ack  = ack_number;
					case (cur.phase)
						PH_SLOW: begin
							nxt.window = win_inc;
							if (win_inc >= cur.threshold) begin
								nxt.phase          = PH_AVOID;
								nxt.acked_in_round = '0;
							end
						end
						PH_AVOID: begin
							if (round_sat >= cur.window) begin
								nxt.window         = win_inc;
								nxt.acked_in_round = '0;
							end else begin
								nxt.acked_in_round = round_sat;
							end
						end
						default: begin
							// leaving recovery: deflate to threshold
							nxt.window         = cur.threshold;
							nxt.phase          = PH_AVOID;
							nxt.acked_in_round = '0;
						end
					endcase
				end
			end
			MODE_TIMEOUT: begin
				// threshold is cut only once per ack value
				if (ack_number != cur.timeout_ack) begin
					nxt.timeout_ack = ack_number;
					nxt.threshold   = half_thr;
				end
				nxt.dup_count = 2'd0;
				nxt.window    = TIMEOUT_WINDOW;
				nxt.phase     = PH_SLOW;
			end
			MODE_CONFIRM: begin
				if (cur.phase == PH_RETX) begin
					nxt.phase = PH_RECOV;
					confirmed = 1'b1;
				end
			end
			MODE_QUERY: begin
				allowed = (next_sequence - window_base) < cur.window;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	always_comb begin
		res.window_size  = nxt.window;
		res.threshold    = nxt.threshold;
		res.phase        = phase_code(nxt.phase);
		res.confirmed    = confirmed;
		res.send_allowed = allowed;
	end

endmodule
